/* rtl/mvr_pkg.sv */
// shared types and constants for the midi voice router and note tracker
package mvr_pkg;

  localparam int NOTES       = 128;
  localparam int NOTE_W      = 7;
  localparam int CHAN_W      = 4;
  localparam int SLOT_W      = 2;
  localparam int COUNT_OUT_W = 32;

  // configuration register widths and port sizes
  localparam int DV_CHAN_W   = 16;
  localparam int DV_NOTE_W   = 28;
  localparam int DV_EN_W     = 4;
  localparam int TRK_CHAN_W  = 12;
  localparam int TRK_EN_W    = 3;
  localparam int CFG_DATA_W  = 28;
  localparam int CFG_IDX_W   = 3;

  localparam logic [DV_CHAN_W-1:0] DV_CHAN_RST = 16'h9999;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DV_CHAN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DV_NOTE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DV_EN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRK_CHAN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRK_EN   = 3'd4;

  localparam logic signed [7:0] NOTE_NONE = -8'sd1;

  typedef enum logic [1:0] {
    EV_NOTE_ON  = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_CLOCK    = 2'd2,
    EV_OTHER    = 2'd3
  } mvr_kind_t;

  typedef enum logic [2:0] {
    RK_IGNORED  = 3'd0,
    RK_CLOCK    = 3'd1,
    RK_DRUM_HIT = 3'd2,
    RK_NOTE_ON  = 3'd3,
    RK_NOTE_OFF = 3'd4,
    RK_OTHER    = 3'd5
  } mvr_rkind_t;

  typedef struct packed {
    mvr_kind_t          kind;
    logic [CHAN_W-1:0]  channel;
    logic [NOTE_W-1:0]  note;
  } mvr_in_t;

  typedef struct packed {
    mvr_rkind_t              result_kind;
    logic [SLOT_W-1:0]       slot;
    logic signed [7:0]       highest_note;
    logic [COUNT_OUT_W-1:0]  event_count;
  } mvr_out_t;

endpackage

/* rtl/midi_voice_router_note_tracker.sv */
// midi voice router and note tracker: drum matching, track routing, note maps
// path: the input register loads at the input accept edge, the result register when
//   the word fires, which waits while the output stalls; map update and encode sit between
// throughput: one word per cycle, back to back on a track, unless the output stalls
// reset: synchronous, active low; clears valids, counters and note maps,
//   sets every track's highest note to -1 and the registers to their defaults
module midi_voice_router_note_tracker
  import mvr_pkg::*;
#(
  parameter int DRUM_VOICES    = 4,
  parameter int MELODIC_TRACKS = 3,
  parameter int COUNT_BITS     = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mvr_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mvr_out_t               out_data,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int VOI_IW = (DRUM_VOICES > 1) ? $clog2(DRUM_VOICES) : 1;
  localparam int TRK_IW = (MELODIC_TRACKS > 1) ? $clog2(MELODIC_TRACKS) : 1;

  // highest set bit of a byte, msb of result flags any bit set
  function automatic logic [3:0] top8(input logic [7:0] b);
    logic       any;
    logic [2:0] idx;
    any = 1'b0;
    idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        any = 1'b1;
        idx = 3'(i);
      end
    end
    return {any, idx};
  endfunction

  // highest set bit of the note map as two levels of byte encoders
  function automatic logic signed [7:0] top128(input logic [NOTES-1:0] m);
    logic [15:0] gany;
    logic [2:0]  gidx [16];
    logic [3:0]  r;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [3:0]  grp;
    logic signed [7:0] res;
    for (int g = 0; g < 16; g++) begin
      r       = top8(m[8*g +: 8]);
      gany[g] = r[3];
      gidx[g] = r[2:0];
    end
    hi  = top8(gany[15:8]);
    lo  = top8(gany[7:0]);
    grp = hi[3] ? {1'b1, hi[2:0]} : {1'b0, lo[2:0]};
    if (hi[3] || lo[3]) begin
      res = $signed({1'b0, grp, gidx[grp]});
    end else begin
      res = NOTE_NONE;
    end
    return res;
  endfunction

  // configuration
  logic [DV_CHAN_W-1:0]  cfg_dv_chan_r;
  logic [DV_NOTE_W-1:0]  cfg_dv_note_r;
  logic [DV_EN_W-1:0]    cfg_dv_en_r;
  logic [TRK_CHAN_W-1:0] cfg_trk_chan_r;
  logic [TRK_EN_W-1:0]   cfg_trk_en_r;

  // handshake and pipeline registers
  logic     in_vld_r;
  mvr_in_t  in_q_r;
  logic     out_vld_r;
  mvr_out_t out_q_r;
  logic     fire;

  // tracker state
  logic [NOTES-1:0]      map_r          [MELODIC_TRACKS];
  logic signed [7:0]     trk_highest_r  [MELODIC_TRACKS];
  logic [NOTE_W-1:0]     trk_last_note_r[MELODIC_TRACKS];
  logic [COUNT_BITS-1:0] trk_on_cnt_r   [MELODIC_TRACKS];
  logic [COUNT_BITS-1:0] voice_hits_r   [DRUM_VOICES];
  logic [COUNT_BITS-1:0] drum_total_r;
  logic [NOTE_W-1:0]     drum_last_note_r;
  logic [COUNT_BITS-1:0] clk_pulses_r;

  // datapath
  logic                  drum_hit;
  logic [VOI_IW-1:0]     voi_sel;
  logic                  trk_hit;
  logic [TRK_IW-1:0]     trk_sel;
  logic [NOTES-1:0]      note_bit;
  logic [NOTES-1:0]      map_nxt;
  logic signed [7:0]     top_nxt;
  logic [COUNT_BITS-1:0] clk_pulses_nxt;
  logic [COUNT_BITS-1:0] voice_cnt_nxt;
  logic [COUNT_BITS-1:0] trk_cnt_nxt;
  mvr_out_t              res_nxt;

  assign fire      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || fire;
  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;

  always_comb begin
    drum_hit = 1'b0;
    voi_sel  = '0;
    // descending scan so the lowest matching voice wins
    for (int v = DRUM_VOICES - 1; v >= 0; v--) begin
      if (cfg_dv_en_r[v] && (cfg_dv_chan_r[CHAN_W*v +: CHAN_W] == in_q_r.channel) &&
          (cfg_dv_note_r[NOTE_W*v +: NOTE_W] == in_q_r.note) &&
          (in_q_r.kind == EV_NOTE_ON)) begin
        drum_hit = 1'b1;
        voi_sel  = VOI_IW'(v);
      end
    end

    trk_hit = 1'b0;
    trk_sel = '0;
    for (int t = MELODIC_TRACKS - 1; t >= 0; t--) begin
      if (cfg_trk_en_r[t] && (cfg_trk_chan_r[CHAN_W*t +: CHAN_W] == in_q_r.channel)) begin
        trk_hit = 1'b1;
        trk_sel = TRK_IW'(t);
      end
    end

    note_bit = {{(NOTES-1){1'b0}}, 1'b1} << in_q_r.note;
    unique case (in_q_r.kind)
      EV_NOTE_ON:  map_nxt = map_r[trk_sel] | note_bit;
      EV_NOTE_OFF: map_nxt = map_r[trk_sel] & ~note_bit;
      EV_CLOCK:    map_nxt = map_r[trk_sel];
      EV_OTHER:    map_nxt = map_r[trk_sel];
      default:     map_nxt = map_r[trk_sel];
    endcase
    top_nxt = top128(map_nxt);

    clk_pulses_nxt = clk_pulses_r + 1'b1;
    voice_cnt_nxt  = voice_hits_r[voi_sel] + 1'b1;
    trk_cnt_nxt    = trk_on_cnt_r[trk_sel] + 1'b1;

    res_nxt.result_kind  = RK_IGNORED;
    res_nxt.slot         = '0;
    res_nxt.highest_note = NOTE_NONE;
    res_nxt.event_count  = '0;
    priority if (in_q_r.kind == EV_CLOCK) begin
      res_nxt.result_kind = RK_CLOCK;
      res_nxt.event_count = COUNT_OUT_W'(clk_pulses_nxt);
    end else if (drum_hit) begin
      res_nxt.result_kind = RK_DRUM_HIT;
      res_nxt.slot        = SLOT_W'(voi_sel);
      res_nxt.event_count = COUNT_OUT_W'(voice_cnt_nxt);
    end else if (trk_hit) begin
      res_nxt.slot         = SLOT_W'(trk_sel);
      res_nxt.highest_note = top_nxt;
      unique case (in_q_r.kind)
        EV_NOTE_ON: begin
          res_nxt.result_kind = RK_NOTE_ON;
          res_nxt.event_count = COUNT_OUT_W'(trk_cnt_nxt);
        end
        EV_NOTE_OFF: res_nxt.result_kind = RK_NOTE_OFF;
        default:     res_nxt.result_kind = RK_OTHER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dv_chan_r    <= DV_CHAN_RST;
      cfg_dv_note_r    <= '0;
      cfg_dv_en_r      <= '0;
      cfg_trk_chan_r   <= '0;
      cfg_trk_en_r     <= '0;
      in_vld_r         <= 1'b0;
      out_vld_r        <= 1'b0;
      drum_total_r     <= '0;
      drum_last_note_r <= '0;
      clk_pulses_r     <= '0;
      for (int t = 0; t < MELODIC_TRACKS; t++) begin
        map_r[t]           <= '0;
        trk_highest_r[t]   <= NOTE_NONE;
        trk_last_note_r[t] <= '0;
        trk_on_cnt_r[t]    <= '0;
      end
      for (int v = 0; v < DRUM_VOICES; v++) begin
        voice_hits_r[v] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DV_CHAN:  cfg_dv_chan_r  <= cfg_data[DV_CHAN_W-1:0];
          CFG_DV_NOTE:  cfg_dv_note_r  <= cfg_data[DV_NOTE_W-1:0];
          CFG_DV_EN:    cfg_dv_en_r    <= cfg_data[DV_EN_W-1:0];
          CFG_TRK_CHAN: cfg_trk_chan_r <= cfg_data[TRK_CHAN_W-1:0];
          CFG_TRK_EN:   cfg_trk_en_r   <= cfg_data[TRK_EN_W-1:0];
          default: ;
        endcase
      end

      if (in_ready) begin
        in_vld_r <= in_valid;
      end

      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end

      if (fire) begin
        priority if (in_q_r.kind == EV_CLOCK) begin
          clk_pulses_r <= clk_pulses_nxt;
        end else if (drum_hit) begin
          voice_hits_r[voi_sel] <= voice_cnt_nxt;
          drum_total_r          <= drum_total_r + 1'b1;
          drum_last_note_r      <= in_q_r.note;
        end else if (trk_hit) begin
          map_r[trk_sel]         <= map_nxt;
          trk_highest_r[trk_sel] <= top_nxt;
          if (in_q_r.kind == EV_NOTE_ON) begin
            trk_last_note_r[trk_sel] <= in_q_r.note;
            trk_on_cnt_r[trk_sel]    <= trk_cnt_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_r <= in_data;
    end
    if (fire) begin
      out_q_r <= res_nxt;
    end
  end

endmodule

/* rtl/mvr_checker.sv */
// port-level checks for the midi voice router and note tracker
module mvr_checker
  import mvr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input mvr_out_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // only track results carry a highest note
  a_no_track_note: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == RK_IGNORED || out_data.result_kind == RK_CLOCK ||
                  out_data.result_kind == RK_DRUM_HIT)
    |-> out_data.highest_note == NOTE_NONE)
    else $error("highest note set on a non-track result");

  // a track note on has just set a bit, so some note is active
  a_note_on_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == RK_NOTE_ON |-> out_data.highest_note != NOTE_NONE)
    else $error("note on left the track empty");

  // results that bump no counter report zero
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == RK_IGNORED || out_data.result_kind == RK_NOTE_OFF ||
                  out_data.result_kind == RK_OTHER)
    |-> out_data.event_count == '0)
    else $error("count on a result without a counter");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == RK_IGNORED || out_data.result_kind == RK_CLOCK)
    |-> out_data.slot == '0)
    else $error("slot set on ignored or clock result");

endmodule

bind midi_voice_router_note_tracker mvr_checker u_mvr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
